[rtl/rbsi_pkg.sv]
`default_nettype none
package rbsi_pkg;

  localparam int COEF_FRAC_BITS = 30;
  localparam int NUM_AXES = 3;
  localparam int NUM_PAIRS = 6;

  // Configuration register indexes.
  localparam logic [2:0] REG_LOW_X  = 3'd0;
  localparam logic [2:0] REG_LOW_Y  = 3'd1;
  localparam logic [2:0] REG_LOW_Z  = 3'd2;
  localparam logic [2:0] REG_HIGH_X = 3'd3;
  localparam logic [2:0] REG_HIGH_Y = 3'd4;
  localparam logic [2:0] REG_HIGH_Z = 3'd5;

  // Rotation matrix, row major, round(c * 2^30).
  localparam logic signed [31:0] ROT_Q30 [9] = '{
    32'sd988957600,  32'sd24388440,   32'sd417480028,
    32'sd49665,      32'sd1071907470, -32'sd62736576,
    -32'sd418191783, 32'sd57802114,   32'sd987266961
  };

  // Cross-axis pairs (i, k) for the test t1_i <= t2_k.
  localparam logic [1:0] PAIR_I [NUM_PAIRS] = '{2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2};
  localparam logic [1:0] PAIR_K [NUM_PAIRS] = '{2'd1, 2'd2, 2'd0, 2'd2, 2'd0, 2'd1};

  typedef logic signed [63:0] wide_t;

  typedef struct packed {
    logic        zero;
    logic        neg;
    logic [63:0] mag;
  } snum_t;

  typedef struct packed {
    logic        dz;
    logic        in_slab;
    snum_t       n1;
    snum_t       n2;
    logic [63:0] dm;
  } slab_t;

  typedef struct packed {
    logic dz;
    logic in_slab;
    logic n1_zero;
    logic n1_neg;
    logic n2_zero;
    logic n2_neg;
  } meta_t;

  // Coefficient at COEF_FRAC_BITS fraction bits, rounded half up from Q1.30.
  function automatic logic signed [31:0] coef_at(input int idx);
    logic [63:0] u;
    logic [63:0] half;
    logic [63:0] bias;
    logic [63:0] r;
    bias = 64'd1 << 31;
    u = 64'(ROT_Q30[idx]) + bias;
    half = (64'd1 << (30 - COEF_FRAC_BITS)) >> 1;
    r = ((u + half) >> (30 - COEF_FRAC_BITS)) - (bias >> (30 - COEF_FRAC_BITS));
    return r[31:0];
  endfunction

endpackage
`default_nettype wire

[rtl/rbsi_rotate.sv]
`default_nettype none
module rbsi_rotate import rbsi_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               adv,
  input  wire logic               in_valid,
  input  wire logic signed [31:0] vtx [NUM_AXES],
  input  wire logic signed [31:0] mom [NUM_AXES],
  output logic                    valid,
  output wide_t                   p [NUM_AXES],
  output wide_t                   d [NUM_AXES]
);

  logic                v1;
  logic                v2;
  logic signed [31:0]  vr [NUM_AXES];
  logic signed [31:0]  mr [NUM_AXES];
  wide_t               pp [9];
  wide_t               pd [9];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      valid <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < NUM_AXES; j++) begin
        vr[j] <= vtx[j];
        mr[j] <= mom[j];
      end
      // One 32 x 32 product per coefficient and operand.
      for (int i = 0; i < NUM_AXES; i++) begin
        for (int j = 0; j < NUM_AXES; j++) begin
          pp[i*3+j] <= wide_t'(coef_at(i*3+j)) * wide_t'(vr[j]);
          pd[i*3+j] <= wide_t'(coef_at(i*3+j)) * wide_t'(mr[j]);
        end
      end
      for (int i = 0; i < NUM_AXES; i++) begin
        p[i] <= pp[i*3] + pp[i*3+1] + pp[i*3+2];
        d[i] <= pd[i*3] + pd[i*3+1] + pd[i*3+2];
      end
    end
  end

endmodule
`default_nettype wire

[rtl/rbsi_slab.sv]
`default_nettype none
module rbsi_slab import rbsi_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               adv,
  input  wire logic               in_valid,
  input  wire wide_t              p [NUM_AXES],
  input  wire wide_t              d [NUM_AXES],
  input  wire logic signed [31:0] box_low [NUM_AXES],
  input  wire logic signed [31:0] box_high [NUM_AXES],
  output logic                    valid,
  output slab_t                   slab [NUM_AXES]
);

  logic        v4;
  logic        dz4 [NUM_AXES];
  logic        in4 [NUM_AXES];
  wide_t       a4 [NUM_AXES];
  wide_t       b4 [NUM_AXES];
  logic [63:0] dm4 [NUM_AXES];

  wide_t lo [NUM_AXES];
  wide_t hi [NUM_AXES];

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      lo[i] = wide_t'(box_low[i]) <<< COEF_FRAC_BITS;
      hi[i] = wide_t'(box_high[i]) <<< COEF_FRAC_BITS;
    end
  end

  function automatic snum_t to_snum(input wide_t x);
    snum_t s;
    s.zero = (x == '0);
    s.neg = x[63];
    s.mag = x[63] ? 64'(-x) : 64'(x);
    return s;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      valid <= 1'b0;
    end else if (adv) begin
      v4 <= in_valid;
      valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // Negating the direction flips the numerators, so one subtract serves.
      for (int i = 0; i < NUM_AXES; i++) begin
        dz4[i] <= (d[i] == '0);
        in4[i] <= (p[i] >= lo[i]) && (p[i] <= hi[i]);
        a4[i]  <= d[i][63] ? p[i] - lo[i] : lo[i] - p[i];
        b4[i]  <= d[i][63] ? p[i] - hi[i] : hi[i] - p[i];
        dm4[i] <= d[i][63] ? 64'(-d[i]) : 64'(d[i]);
      end
      for (int i = 0; i < NUM_AXES; i++) begin
        slab[i].dz      <= dz4[i];
        slab[i].in_slab <= in4[i];
        slab[i].dm      <= dm4[i];
        if (a4[i] > b4[i]) begin
          slab[i].n1 <= to_snum(b4[i]);
          slab[i].n2 <= to_snum(a4[i]);
        end else begin
          slab[i].n1 <= to_snum(a4[i]);
          slab[i].n2 <= to_snum(b4[i]);
        end
      end
    end
  end

endmodule
`default_nettype wire

[rtl/rbsi_cross_mul.sv]
`default_nettype none
module rbsi_cross_mul import rbsi_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  adv,
  input  wire logic  in_valid,
  input  wire slab_t slab [NUM_AXES],
  output logic       valid,
  output meta_t      meta [NUM_AXES],
  output logic [127:0] prod_a [NUM_PAIRS],
  output logic [127:0] prod_b [NUM_PAIRS]
);

  logic        v6;
  meta_t       meta6 [NUM_AXES];
  logic [63:0] ppa [NUM_PAIRS][4];
  logic [63:0] ppb [NUM_PAIRS][4];

  function automatic logic [127:0] join_pp(input logic [63:0] ll, input logic [63:0] lh,
                                           input logic [63:0] hl, input logic [63:0] hh);
    return {64'd0, ll} + {32'd0, lh, 32'd0} + {32'd0, hl, 32'd0} + {hh, 64'd0};
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
      valid <= 1'b0;
    end else if (adv) begin
      v6 <= in_valid;
      valid <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        meta6[i] <= '{dz: slab[i].dz, in_slab: slab[i].in_slab,
                      n1_zero: slab[i].n1.zero, n1_neg: slab[i].n1.neg,
                      n2_zero: slab[i].n2.zero, n2_neg: slab[i].n2.neg};
      end
      // |n1_i| * |d_k| and |n2_k| * |d_i|, each as four 32 x 32 partial products.
      for (int q = 0; q < NUM_PAIRS; q++) begin
        ppa[q][0] <= 64'(slab[PAIR_I[q]].n1.mag[31:0])  * 64'(slab[PAIR_K[q]].dm[31:0]);
        ppa[q][1] <= 64'(slab[PAIR_I[q]].n1.mag[31:0])  * 64'(slab[PAIR_K[q]].dm[63:32]);
        ppa[q][2] <= 64'(slab[PAIR_I[q]].n1.mag[63:32]) * 64'(slab[PAIR_K[q]].dm[31:0]);
        ppa[q][3] <= 64'(slab[PAIR_I[q]].n1.mag[63:32]) * 64'(slab[PAIR_K[q]].dm[63:32]);
        ppb[q][0] <= 64'(slab[PAIR_K[q]].n2.mag[31:0])  * 64'(slab[PAIR_I[q]].dm[31:0]);
        ppb[q][1] <= 64'(slab[PAIR_K[q]].n2.mag[31:0])  * 64'(slab[PAIR_I[q]].dm[63:32]);
        ppb[q][2] <= 64'(slab[PAIR_K[q]].n2.mag[63:32]) * 64'(slab[PAIR_I[q]].dm[31:0]);
        ppb[q][3] <= 64'(slab[PAIR_K[q]].n2.mag[63:32]) * 64'(slab[PAIR_I[q]].dm[63:32]);
      end
      for (int i = 0; i < NUM_AXES; i++) begin
        meta[i] <= meta6[i];
      end
      for (int q = 0; q < NUM_PAIRS; q++) begin
        prod_a[q] <= join_pp(ppa[q][0], ppa[q][1], ppa[q][2], ppa[q][3]);
        prod_b[q] <= join_pp(ppb[q][0], ppb[q][1], ppb[q][2], ppb[q][3]);
      end
    end
  end

endmodule
`default_nettype wire

[rtl/ray_box_slab_intersect.sv]
`default_nettype none
// Ray versus axis-aligned box test by the slab method, exact fixed point.
// Input channel: in_valid / in_stall carry one beat holding a decay vertex and
// a momentum vector in beam coordinates. Output channel: out_valid / out_stall
// carry one beat holding hits_box, one per input beat, in order.
// Both vectors are rotated into detector coordinates and the forward ray is
// tested against the box held in six configuration registers, written through
// cfg_we / cfg_index / cfg_data; the user must write them only while the
// block is idle, and the block itself does not enforce this.
// Throughput is one beat per cycle when not stalled; the pipeline is eight
// register stages (input, products, row sums, slab numerators, ordering,
// partial products, cross products, result), and the 64 x 64 cross products
// of the slab comparisons are split into 32 x 32 partial products over two
// stages. When the receiver stalls a valid result, the whole pipeline holds
// and in_stall is raised in the same cycle, so no beat is lost or repeated.
// Reset clears all stage valid bits and loads the default box bounds.
module ray_box_slab_intersect import rbsi_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [31:0] vertex_x,
  input  wire logic signed [31:0] vertex_y,
  input  wire logic signed [31:0] vertex_z,
  input  wire logic signed [31:0] mom_x,
  input  wire logic signed [31:0] mom_y,
  input  wire logic signed [31:0] mom_z,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    hits_box,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);

  logic               adv;
  logic signed [31:0] box_low [NUM_AXES];
  logic signed [31:0] box_high [NUM_AXES];
  logic signed [31:0] vtx [NUM_AXES];
  logic signed [31:0] mom [NUM_AXES];

  logic               rot_valid;
  wide_t              p [NUM_AXES];
  wide_t              d [NUM_AXES];
  logic               slab_valid;
  slab_t              slab [NUM_AXES];
  logic               mul_valid;
  meta_t              meta [NUM_AXES];
  logic [127:0]       prod_a [NUM_PAIRS];
  logic [127:0]       prod_b [NUM_PAIRS];
  logic               hit_next;

  // The pipeline advances as one unit unless a finished result is held.
  assign adv = !(out_valid && out_stall);
  assign in_stall = !adv;

  assign vtx = '{vertex_x, vertex_y, vertex_z};
  assign mom = '{mom_x, mom_y, mom_z};

  // Box registers: bounds already have the detector offset removed.
  always_ff @(posedge clk) begin
    if (rst) begin
      box_low[0]  <= 32'sd8035328;
      box_low[1]  <= 32'sd819200;
      box_low[2]  <= 32'sd15385600;
      box_high[0] <= 32'sd8100864;
      box_high[1] <= 32'sd878592;
      box_high[2] <= 32'sd15650816;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LOW_X:  box_low[0]  <= cfg_data;
        REG_LOW_Y:  box_low[1]  <= cfg_data;
        REG_LOW_Z:  box_low[2]  <= cfg_data;
        REG_HIGH_X: box_high[0] <= cfg_data;
        REG_HIGH_Y: box_high[1] <= cfg_data;
        REG_HIGH_Z: box_high[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  rbsi_rotate u_rotate (
    .clk, .rst, .adv, .in_valid,
    .vtx, .mom,
    .valid (rot_valid),
    .p, .d
  );

  rbsi_slab u_slab (
    .clk, .rst, .adv,
    .in_valid (rot_valid),
    .p, .d, .box_low, .box_high,
    .valid (slab_valid),
    .slab
  );

  rbsi_cross_mul u_cross_mul (
    .clk, .rst, .adv,
    .in_valid (slab_valid),
    .slab,
    .valid (mul_valid),
    .meta, .prod_a, .prod_b
  );

  // The ray meets the box when max(0, every t1) <= min(every t2), which is
  // the same as every t2 being non-negative and every entry t1_i lying at or
  // before every exit t2_k. Axes with no direction only need the start point
  // inside their slab.
  always_comb begin
    logic le;
    logic [1:0] ai;
    logic [1:0] ak;
    hit_next = 1'b1;
    for (int i = 0; i < NUM_AXES; i++) begin
      if (meta[i].dz) begin
        if (!meta[i].in_slab) hit_next = 1'b0;
      end else if (meta[i].n2_neg) begin
        hit_next = 1'b0;
      end
    end
    for (int q = 0; q < NUM_PAIRS; q++) begin
      ai = PAIR_I[q];
      ak = PAIR_K[q];
      if (meta[ai].n1_zero && meta[ak].n2_zero) begin
        le = 1'b1;
      end else if (meta[ai].n1_zero) begin
        le = !meta[ak].n2_neg;
      end else if (meta[ak].n2_zero) begin
        le = meta[ai].n1_neg;
      end else if (meta[ai].n1_neg != meta[ak].n2_neg) begin
        le = meta[ai].n1_neg;
      end else if (meta[ai].n1_neg) begin
        le = prod_a[q] >= prod_b[q];
      end else begin
        le = prod_a[q] <= prod_b[q];
      end
      if (!meta[ai].dz && !meta[ak].dz && !le) hit_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= mul_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hits_box <= hit_next;
    end
  end

`ifndef ASSERT_OFF
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_hold_pipe: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> ($stable(mul_valid) && $stable(slab_valid)
                                  && $stable(rot_valid)))
    else $error("pipeline moved while the result was held");

  a_no_input_drains: assert property (@(posedge clk) disable iff (rst)
    (!mul_valid && adv) |=> !out_valid)
    else $error("result appeared without an item behind it");
`endif

endmodule
`default_nettype wire
